FILE: hw/rtl/far_pkg.sv
package far_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_OUT_WIDTH = 33;
  localparam int DEN_OUT_WIDTH = 31;
  localparam int MAG_WIDTH     = 64;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic [OPERAND_WIDTH-1:0] num_a;
    logic [OPERAND_WIDTH-1:0] den_a;
    logic [OPERAND_WIDTH-1:0] num_b;
    logic [OPERAND_WIDTH-1:0] den_b;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_OUT_WIDTH-1:0] res_num;
    logic [DEN_OUT_WIDTH-1:0]        res_den;
    logic                            is_whole;
    logic [1:0]                      status;
  } out_item_t;

endpackage

FILE: hw/rtl/far_div.sv
module far_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [far_pkg::MAG_WIDTH-1:0]  dividend,
  input  logic [far_pkg::MAG_WIDTH-1:0]  divisor,
  output logic                           done,
  output logic [far_pkg::MAG_WIDTH-1:0]  quot,
  output logic [far_pkg::MAG_WIDTH-1:0]  rem
);
  import far_pkg::*;

  localparam int CW = $clog2(MAG_WIDTH + 1);

  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [MAG_WIDTH-1:0] dvs;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(MAG_WIDTH);
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if ({rem, quot[MAG_WIDTH-1]} >= {1'b0, dvs}) begin
        rem <= MAG_WIDTH'({rem, quot[MAG_WIDTH-1]} - {1'b0, dvs});
        quot <= {quot[MAG_WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[MAG_WIDTH-2:0], quot[MAG_WIDTH-1]};
        quot <= {quot[MAG_WIDTH-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  a_done_not_start: assert property (@(posedge clk) disable iff (rst)
    start |=> !done) else $error("divider done right after start");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("divider busy with zero count");
  a_done_fall: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");

endmodule

FILE: hw/rtl/fraction_arith_reduce.sv
// Each item passes S_MUL, S_SUM, S_GCD (Euclid remainder steps), S_DN and S_DQ
// to S_OUT; a zero-denominator or divide-by-zero item goes from S_MUL to S_OUT.
// Each Euclid step and the two final divisions share one bit-serial 64-bit
// divider, one quotient bit a cycle.
// One item at a time: in_ready is low from accept until the result is taken,
// so a new item is accepted only after the last result is taken. Reset (rst,
// synchronous, active high) returns the sequencer to idle.
module fraction_arith_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  far_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output far_pkg::out_item_t out_data
);
  import far_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;
  localparam logic [2:0] S_DQ   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [1:0] kind;
  logic signed [OPERAND_WIDTH-1:0] a, b, c, d;
  logic signed [2*OPERAND_WIDTH-1:0] p0, p1, p2;
  logic signed [2*OPERAND_WIDTH+1:0] n;
  logic [MAG_WIDTH-1:0] un, uq, gx, gy;
  logic neg;
  logic wait_div;

  logic div_start, div_done;
  logic [MAG_WIDTH-1:0] div_a, div_b, div_q, div_r;

  far_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    div_a = gx;
    div_b = gy;
    if (state == S_DN) begin
      div_a = un;
      div_b = gx;
    end else if (state == S_DQ) begin
      div_a = uq;
      div_b = gx;
    end
  end

  logic signed [2*OPERAND_WIDTH+1:0] qx;
  logic [MAG_WIDTH-1:0] nm;
  assign qx = (kind == KIND_DIV) ? (2*OPERAND_WIDTH+2)'(p2)
                                 : (2*OPERAND_WIDTH+2)'(p1);
  assign nm = neg ? MAG_WIDTH'(-un) : un;

  always_comb begin
    case (kind)
      KIND_ADD: n = (2*OPERAND_WIDTH+2)'(p0) + (2*OPERAND_WIDTH+2)'(p2);
      KIND_SUB: n = (2*OPERAND_WIDTH+2)'(p0) - (2*OPERAND_WIDTH+2)'(p2);
      default:  n = (2*OPERAND_WIDTH+2)'(p0);
    endcase
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      wait_div <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind  <= in_data.kind;
            a     <= OPERAND_WIDTH'(in_data.num_a);
            b     <= OPERAND_WIDTH'(in_data.den_a);
            c     <= OPERAND_WIDTH'(in_data.num_b);
            d     <= OPERAND_WIDTH'(in_data.den_b);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (b == '0 || d == '0) begin
            out_data <= '{res_num: '0, res_den: '0, is_whole: 1'b0, status: ST_ZERO_DEN};
            state <= S_OUT;
          end else if (kind == KIND_DIV && c == '0) begin
            out_data <= '{res_num: '0, res_den: '0, is_whole: 1'b0, status: ST_DIV_ZERO};
            state <= S_OUT;
          end else begin
            p0 <= (kind == KIND_MUL) ? a * c : a * d;
            p1 <= b * d;
            p2 <= b * c;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          neg <= (n < 0) != (qx < 0);
          un  <= MAG_WIDTH'(n < 0 ? -n : n);
          uq  <= MAG_WIDTH'(qx < 0 ? -qx : qx);
          gx  <= MAG_WIDTH'(n < 0 ? -n : n);
          gy  <= MAG_WIDTH'(qx < 0 ? -qx : qx);
          state <= S_GCD;
        end
        S_GCD: begin
          if (!wait_div) begin
            if (gy == '0) begin
              div_start <= 1'b1;
              wait_div  <= 1'b1;
              state     <= S_DN;
            end else begin
              div_start <= 1'b1;
              wait_div  <= 1'b1;
            end
          end else if (div_done) begin
            gx <= gy;
            gy <= div_r;
            wait_div <= 1'b0;
          end
        end
        S_DN: begin
          if (div_done) begin
            un <= div_q;
            div_start <= 1'b1;
            state <= S_DQ;
          end
        end
        S_DQ: begin
          if (div_done) begin
            wait_div <= 1'b0;
            out_data <= '{res_num: NUM_OUT_WIDTH'(nm),
                          res_den: DEN_OUT_WIDTH'(div_q),
                          is_whole: (div_q == MAG_WIDTH'(1)),
                          status: ST_OK};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.res_den == '0)
    else $error("error result with nonzero denominator");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |-> out_data.res_den != '0)
    else $error("ok result with zero denominator");

endmodule
